@@ rtl/phcb_pkg.sv @@
// package with types, sizes and states of the plane hit cluster builder
package phcb_pkg;

  localparam int MAX_HITS  = 64;
  localparam int CNT_W     = $clog2(MAX_HITS + 1);
  localparam int IDX_W     = $clog2(MAX_HITS);
  localparam int SUM_W     = $clog2(255 * MAX_HITS + 1);
  localparam int DIV_W     = SUM_W + 8;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int CUT_W     = 9;
  localparam logic [CUT_W-1:0] CUT_RESET = CUT_W'(2);

  localparam logic OP_START  = 1'b0;
  localparam logic OP_APPEND = 1'b1;

  typedef struct packed {
    logic        op;
    logic [7:0]  hit_x;
    logic [7:0]  hit_y;
    logic [15:0] hit_z;
    logic [7:0]  chamber_id;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        store_full;
    logic [6:0]  hit_count;
    logic [15:0] centre_x;
    logic [15:0] centre_y;
    logic [15:0] centre_z;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_DIV_LOAD,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic capture;
    logic start_cluster;
    logic scan_init;
    logic scan_en;
    logic append;
    logic set_full;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic eligible;
    logic full;
    logic cmp_near;
    logic cmp_last;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

@@ rtl/phcb_ctrl.sv @@
// controller state machine of the plane hit cluster builder
module phcb_ctrl
  import phcb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status_i.op == OP_START) begin
          cmd_o.start_cluster = 1'b1;
          state_d             = ST_DIV_LOAD;
        end else if (status_i.eligible) begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN;
        end else begin
          state_d = ST_DIV_LOAD;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.cmp_near) begin
          if (status_i.full) begin
            cmd_o.set_full = 1'b1;
          end else begin
            cmd_o.append = 1'b1;
          end
          state_d = ST_DIV_LOAD;
        end else if (status_i.cmp_last) begin
          state_d = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/phcb_dpath.sv @@
// datapath: hit store, neighbor scan, sums, centroid dividers and result register
module phcb_dpath
  import phcb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  in_item_t         in_item_i,
  input  logic             cfg_we_i,
  input  logic [CUT_W-1:0] cfg_data_i,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o
);

  logic [7:0] mem_x [MAX_HITS];
  logic [7:0] mem_y [MAX_HITS];

  in_item_t          hit_q;
  logic [CUT_W-1:0]  cut_q;
  logic [CNT_W-1:0]  count_q;
  logic [SUM_W-1:0]  sum_x_q, sum_y_q;
  logic [7:0]        chamber_q;
  logic [15:0]       first_z_q;
  logic              acc_q, full_q;
  logic [CNT_W-1:0]  rd_idx_q;
  logic              pend_q;
  logic [7:0]        rd_x_q, rd_y_q;
  logic [DIV_W-1:0]  dvd_x_q, dvd_y_q;
  logic [CNT_W-1:0]  rem_x_q, rem_y_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic              out_valid_q;
  out_item_t         out_item_q;

  logic [7:0] dx, dy, dmax;
  logic       near;
  logic       rd_en;
  logic [CNT_W:0] step_x, step_y;

  function automatic logic [CNT_W:0] div_bit(logic [CNT_W-1:0] rem, logic nb,
                                             logic [CNT_W-1:0] dsr);
    logic [CNT_W:0] sh;
    logic [CNT_W:0] df;
    sh = {rem, nb};
    df = sh - {1'b0, dsr};
    if (sh >= {1'b0, dsr}) begin
      return {df[CNT_W-1:0], 1'b1};
    end
    return {sh[CNT_W-1:0], 1'b0};
  endfunction

  assign dx    = (hit_q.hit_x > rd_x_q) ? hit_q.hit_x - rd_x_q : rd_x_q - hit_q.hit_x;
  assign dy    = (hit_q.hit_y > rd_y_q) ? hit_q.hit_y - rd_y_q : rd_y_q - hit_q.hit_y;
  assign dmax  = (dx > dy) ? dx : dy;
  assign near  = {1'b0, dmax} < cut_q;
  assign rd_en = cmd_i.scan_en && (rd_idx_q < count_q);

  assign step_x = div_bit(rem_x_q, dvd_x_q[DIV_W-1], count_q);
  assign step_y = div_bit(rem_y_q, dvd_y_q[DIV_W-1], count_q);

  always_comb begin
    status_o          = '0;
    status_o.op       = hit_q.op;
    status_o.eligible = (count_q != '0) && (hit_q.chamber_id == chamber_q);
    status_o.full     = count_q == CNT_W'(MAX_HITS);
    status_o.cmp_near = pend_q && near;
    status_o.cmp_last = pend_q && (rd_idx_q == count_q);
    status_o.div_last = div_cnt_q == DIV_CNT_W'(DIV_W - 1);
    status_o.out_busy = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q       <= CUT_RESET;
      count_q     <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      chamber_q   <= '0;
      first_z_q   <= '0;
      acc_q       <= 1'b0;
      full_q      <= 1'b0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cut_q <= cfg_data_i;
      end
      if (cmd_i.capture) begin
        acc_q  <= 1'b0;
        full_q <= 1'b0;
      end
      if (cmd_i.start_cluster) begin
        count_q   <= CNT_W'(1);
        sum_x_q   <= SUM_W'(hit_q.hit_x);
        sum_y_q   <= SUM_W'(hit_q.hit_y);
        chamber_q <= hit_q.chamber_id;
        first_z_q <= hit_q.hit_z;
        acc_q     <= 1'b1;
      end
      if (cmd_i.append) begin
        count_q <= count_q + CNT_W'(1);
        sum_x_q <= sum_x_q + SUM_W'(hit_q.hit_x);
        sum_y_q <= sum_y_q + SUM_W'(hit_q.hit_y);
        acc_q   <= 1'b1;
      end
      if (cmd_i.set_full) begin
        full_q <= 1'b1;
      end
      if (cmd_i.scan_init) begin
        rd_idx_q <= '0;
        pend_q   <= 1'b0;
      end else if (cmd_i.scan_en) begin
        pend_q <= rd_en;
        if (rd_en) begin
          rd_idx_q <= rd_idx_q + CNT_W'(1);
        end
      end
      if (cmd_i.div_load) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      hit_q <= in_item_i;
    end
    if (cmd_i.start_cluster) begin
      mem_x[0] <= hit_q.hit_x;
      mem_y[0] <= hit_q.hit_y;
    end else if (cmd_i.append) begin
      mem_x[count_q[IDX_W-1:0]] <= hit_q.hit_x;
      mem_y[count_q[IDX_W-1:0]] <= hit_q.hit_y;
    end
    if (rd_en) begin
      rd_x_q <= mem_x[rd_idx_q[IDX_W-1:0]];
      rd_y_q <= mem_y[rd_idx_q[IDX_W-1:0]];
    end
    if (cmd_i.div_load) begin
      dvd_x_q <= {sum_x_q, 8'h00};
      dvd_y_q <= {sum_y_q, 8'h00};
      rem_x_q <= '0;
      rem_y_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_x_q <= {dvd_x_q[DIV_W-2:0], step_x[0]};
      dvd_y_q <= {dvd_y_q[DIV_W-2:0], step_y[0]};
      rem_x_q <= step_x[CNT_W:1];
      rem_y_q <= step_y[CNT_W:1];
    end
    if (cmd_i.out_load) begin
      out_item_q.accepted   <= acc_q;
      out_item_q.store_full <= full_q;
      out_item_q.hit_count  <= 7'(count_q);
      out_item_q.centre_x   <= (count_q == '0) ? 16'h0000 : 16'(dvd_x_q);
      out_item_q.centre_y   <= (count_q == '0) ? 16'h0000 : 16'(dvd_y_q);
      out_item_q.centre_z   <= first_z_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/plane_hit_cluster_builder_top.sv @@
// top level of the plane hit cluster builder
// One request is handled at a time. A start request passes from acceptance
// through the evaluation, divider load, divide and finish states to a loaded
// result, and the block is then ready again; an append that reaches the
// neighbor scan also passes the scan state, in which the stored hits are read
// one per cycle through the single read port of the hit store, and the scan
// stops at the first near hit. DIV_W (22) one-bit restoring steps compute both
// centroid coordinates side by side. A new request is taken while the previous
// result still waits in the output register, but a finished result is loaded
// only once that register is free. The hit store is not cleared.
module plane_hit_cluster_builder_top
  import phcb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [CUT_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  phcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  phcb_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in work");

  a_no_append_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.append |-> !status.full)
    else $error("hit appended to a full store");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.accepted && out_item_o.store_full))
    else $error("result both accepted and full");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && !out_ready_i))
    else $error("result register overwritten");

endmodule
